// ===== rtl/dmtlb_pkg.sv =====
// shared types, constants and sizing for the direct-mapped translation buffer
// no dependencies; imported by every rtl module of the block
package dmtlb_pkg;

  localparam int ENTRY_COUNT  = 512;
  localparam int OFFSET_WIDTH = 12;
  localparam int FRAME_WIDTH  = 20;

  localparam int VADDR_WIDTH     = 32;
  localparam int FRAME_IN_WIDTH  = 20;
  localparam int COUNT_WIDTH     = 48;
  localparam int VPN_WIDTH       = VADDR_WIDTH - OFFSET_WIDTH;
  localparam int INDEX_WIDTH     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int RECIP_SHIFT     = VPN_WIDTH + INDEX_WIDTH;
  localparam int RECIP_WIDTH     = VPN_WIDTH + 2;
  localparam int PROD_WIDTH      = VPN_WIDTH + RECIP_WIDTH;
  localparam int QN_WIDTH        = VPN_WIDTH + INDEX_WIDTH + 1;
  localparam int PHYS_RAW_WIDTH  = FRAME_WIDTH + OFFSET_WIDTH;

  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(ENTRY_COUNT);
  localparam logic [RECIP_WIDTH-1:0] RECIP = RECIP_FULL[RECIP_WIDTH-1:0];
  localparam logic [VPN_WIDTH-1:0] ENTRIES_VPN = VPN_WIDTH'(ENTRY_COUNT);
  localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(ENTRY_COUNT - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_FILL       = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic [VADDR_WIDTH-1:0]    vaddr;
    logic [FRAME_IN_WIDTH-1:0] frame;
  } in_word_t;

  typedef struct packed {
    logic                   hit;
    logic [VADDR_WIDTH-1:0] paddr;
    logic                   status;
    logic [COUNT_WIDTH-1:0] lookups_seen;
    logic [COUNT_WIDTH-1:0] misses_seen;
  } out_word_t;

  typedef struct packed {
    logic                   valid;
    logic [VPN_WIDTH-1:0]   tag;
    logic [FRAME_WIDTH-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic [INDEX_WIDTH-1:0] addr;
    entry_t                 wr_data;
  } store_req_t;

  typedef struct packed {
    logic lookup;
    logic miss;
  } cnt_ctl_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] lookups;
    logic [COUNT_WIDTH-1:0] misses;
  } cnt_t;

endpackage

// ===== rtl/dmtlb_index.sv =====
// page number to entry index reduction: reciprocal multiply, back multiply, one correction
// depends on dmtlb_pkg; quot and then qn are registered before index is valid
module dmtlb_index
  import dmtlb_pkg::*;
(
  input  logic                   clk,
  input  logic [VPN_WIDTH-1:0]   vpn,
  output logic [INDEX_WIDTH-1:0] index
);

  logic [VPN_WIDTH-1:0]  quot;
  logic [VPN_WIDTH-1:0]  qn;
  logic [PROD_WIDTH-1:0] prod;
  logic [QN_WIDTH-1:0]   qn_full;
  logic [VPN_WIDTH-1:0]  diff;
  logic [VPN_WIDTH-1:0]  rem;

  assign prod = PROD_WIDTH'(vpn) * PROD_WIDTH'(RECIP);

  always_ff @(posedge clk) begin
    quot <= VPN_WIDTH'(prod >> RECIP_SHIFT);
    qn   <= qn_full[VPN_WIDTH-1:0];
  end

  assign qn_full = QN_WIDTH'(quot) * QN_WIDTH'(ENTRY_COUNT);

  // estimate is exact or one short, so the remainder stays below twice the count
  always_comb begin
    diff = vpn - qn;
    rem  = (diff >= ENTRIES_VPN) ? diff - ENTRIES_VPN : diff;
  end

  assign index = rem[INDEX_WIDTH-1:0];

endmodule

// ===== rtl/dmtlb_store.sv =====
// entry memory holding valid, tag and frame, one read or write port, registered read
// depends on dmtlb_pkg; sweeps every entry to invalid after reset
module dmtlb_store
  import dmtlb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output entry_t     rd_data,
  output logic       busy
);

  entry_t                 mem [ENTRY_COUNT];
  logic [INDEX_WIDTH-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      sweep_addr <= sweep_addr + INDEX_WIDTH'(1);
      if (sweep_addr == LAST_INDEX) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ===== rtl/dmtlb_count.sv =====
// saturating lookup and miss counters
// depends on dmtlb_pkg; presents the value each counter takes after this word
module dmtlb_count
  import dmtlb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cnt_ctl_t ctl,
  output cnt_t     cnt_next
);

  cnt_t cnt;

  always_comb begin
    cnt_next = cnt;
    if (ctl.lookup && cnt.lookups != COUNT_MAX) begin
      cnt_next.lookups = cnt.lookups + COUNT_WIDTH'(1);
    end
    if (ctl.miss && cnt.misses != COUNT_MAX) begin
      cnt_next.misses = cnt.misses + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== rtl/direct_mapped_tlb.sv =====
// direct-mapped translation buffer top level: sequencer, output register
// depends on dmtlb_pkg, dmtlb_index, dmtlb_store and dmtlb_count
//
//   channel  signals                    payload
//   in       in_valid / in_ready        in_data   (in_word_t: op, vaddr, frame)
//   out      out_valid / out_ready      out_data  (out_word_t: hit, paddr, status, counts)
//
// from acceptance to the next acceptance a word passes DIV1 and DIV2 for the index
// reduction multiplies, READ for the entry memory read and CHECK to check and write back
// after reset the entry memory is swept entry by entry with in_ready low
// a result waits in the output register; the next word is taken meanwhile and
// stalls in the check step only while the output register is still full
module direct_mapped_tlb
  import dmtlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t                 state;
  state_t                 state_next;
  in_word_t               item;
  logic [INDEX_WIDTH-1:0] idx;
  logic [INDEX_WIDTH-1:0] index;
  logic [VPN_WIDTH-1:0]   vpn;
  logic                   busy;
  store_req_t             req;
  entry_t                 rd_data;
  cnt_ctl_t               ctl;
  cnt_t                   cnt_next;
  out_word_t              result;
  logic                   finish;
  logic                   is_null;
  logic                   match;
  logic [PHYS_RAW_WIDTH-1:0] phys_raw;

  assign vpn     = item.vaddr[VADDR_WIDTH-1:OFFSET_WIDTH];
  assign is_null = (item.vaddr == '0);
  assign match   = rd_data.valid && (rd_data.tag == vpn);
  assign phys_raw = {rd_data.frame, item.vaddr[OFFSET_WIDTH-1:0]};

  dmtlb_index u_index (
    .clk   (clk),
    .vpn   (vpn),
    .index (index)
  );

  dmtlb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data),
    .busy    (busy)
  );

  dmtlb_count u_count (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cnt_next (cnt_next)
  );

  assign in_ready = (state == ST_IDLE) && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req         = '0;
    req.addr    = idx;
    ctl         = '0;
    finish      = 1'b0;
    result      = '0;
    result.paddr = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: begin
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        req.rd_en  = 1'b1;
        req.addr   = index;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
          if (is_null) begin
            result.status = 1'b1;
          end else begin
            case (item.op)
              OP_LOOKUP: begin
                ctl.lookup = 1'b1;
                ctl.miss   = !match;
                if (match) begin
                  result.hit   = 1'b1;
                  result.paddr = VADDR_WIDTH'(phys_raw);
                end
              end
              OP_FILL: begin
                req.wr_en         = 1'b1;
                req.wr_data.valid = 1'b1;
                req.wr_data.tag   = vpn;
                req.wr_data.frame = item.frame[FRAME_WIDTH-1:0];
              end
              OP_INVALIDATE: begin
                req.wr_en         = match;
                req.wr_data       = rd_data;
                req.wr_data.valid = 1'b0;
              end
              default: begin
              end
            endcase
          end
          result.lookups_seen = cnt_next.lookups;
          result.misses_seen  = cnt_next.misses;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (state == ST_READ) begin
      idx <= index;
    end
    if (finish) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
